// ===== sv/ils_pkg.sv =====
// Package for the indexed list store: sizes, command and status codes,
// beat and control struct types.
// Depends on nothing; every other file of the block refers to it.
package ils_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMP_W      = (CNT_W > 7) ? CNT_W : 7;
    localparam int GRP_SIZE   = 8;
    localparam int GRP_NUM    = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic [2:0] CMD_READ     = 3'd0;
    localparam logic [2:0] CMD_INS_HEAD = 3'd1;
    localparam logic [2:0] CMD_INS_TAIL = 3'd2;
    localparam logic [2:0] CMD_INS_POS  = 3'd3;
    localparam logic [2:0] CMD_DEL_POS  = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [7:0]  position;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         entry_count;
    } t_out_beat;

    typedef struct packed {
        logic                  ins;
        logic                  del;
        logic [CMP_W-1:0]      pos;
        logic                  rd;
        logic [CMP_W-1:0]      rd_pos;
        logic [WORD_WIDTH-1:0] word;
    } t_cell_ctl;

    typedef struct packed {
        logic             is_read;
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } t_dec_res;

endpackage

// ===== sv/ils_cell.sv =====
// One storage cell of the indexed list store chain.
// Depends on ils_pkg for the word width and the control struct.
module ils_cell (
    input  logic                           i_clk,
    input  logic [ils_pkg::CMP_W-1:0]      i_index,
    input  ils_pkg::t_cell_ctl             i_ctl,
    input  logic [ils_pkg::WORD_WIDTH-1:0] i_prev,
    input  logic [ils_pkg::WORD_WIDTH-1:0] i_next,
    output logic [ils_pkg::WORD_WIDTH-1:0] o_word,
    output logic [ils_pkg::WORD_WIDTH-1:0] o_rd_word
);

    logic [ils_pkg::WORD_WIDTH-1:0] r_word;
    logic [ils_pkg::WORD_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.ins && (i_index > i_ctl.pos)) begin
            n_word = i_prev;
        end else if (i_ctl.ins && (i_index == i_ctl.pos)) begin
            n_word = i_ctl.word;
        end else if (i_ctl.del && (i_index >= i_ctl.pos)) begin
            n_word = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word    = r_word;
    assign o_rd_word = (i_ctl.rd && (i_index == i_ctl.rd_pos)) ? r_word : '0;

endmodule

// ===== sv/ils_dec.sv =====
// Command decoder of the indexed list store: range and full checks,
// the new count and the control broadcast to the cell chain.
// Depends on ils_pkg.
module ils_dec (
    input  logic                      i_fire,
    input  ils_pkg::t_in_beat         i_beat,
    input  logic [ils_pkg::CNT_W-1:0] i_count,
    output ils_pkg::t_cell_ctl        o_ctl,
    output ils_pkg::t_dec_res         o_res
);

    logic                      w_neg;
    logic [ils_pkg::CMP_W-1:0] w_pos;
    logic [ils_pkg::CMP_W-1:0] w_cnt;
    logic                      w_lt;
    logic                      w_le;
    logic                      w_full;

    assign w_neg  = i_beat.position[7];
    assign w_pos  = ils_pkg::CMP_W'(i_beat.position[6:0]);
    assign w_cnt  = ils_pkg::CMP_W'(i_count);
    assign w_lt   = !w_neg && (w_pos < w_cnt);
    assign w_le   = !w_neg && (w_pos <= w_cnt);
    assign w_full = (i_count == ils_pkg::CNT_W'(ils_pkg::DEPTH));

    always_comb begin
        o_ctl         = '0;
        o_ctl.word    = ils_pkg::WORD_WIDTH'(unsigned'(i_beat.value));
        o_ctl.rd_pos  = w_pos;
        o_res.is_read = 1'b0;
        o_res.status  = ils_pkg::ST_DONE;
        o_res.count   = i_count;
        case (i_beat.command)
            ils_pkg::CMD_READ: begin
                o_res.is_read = 1'b1;
                o_ctl.rd      = i_fire && w_lt;
                if (!w_lt) begin
                    o_res.status = ils_pkg::ST_RANGE;
                end
            end
            ils_pkg::CMD_INS_HEAD, ils_pkg::CMD_INS_TAIL, ils_pkg::CMD_INS_POS: begin
                if (i_beat.command == ils_pkg::CMD_INS_HEAD) begin
                    o_ctl.pos = '0;
                end else if (i_beat.command == ils_pkg::CMD_INS_TAIL) begin
                    o_ctl.pos = w_cnt;
                end else begin
                    o_ctl.pos = w_pos;
                end
                if ((i_beat.command == ils_pkg::CMD_INS_POS) && !w_le) begin
                    o_res.status = ils_pkg::ST_RANGE;
                end else if (w_full) begin
                    o_res.status = ils_pkg::ST_FULL;
                end else begin
                    o_ctl.ins   = i_fire;
                    o_res.count = i_count + 1'b1;
                end
            end
            ils_pkg::CMD_DEL_POS: begin
                o_ctl.pos = w_pos;
                if (!w_lt) begin
                    o_res.status = ils_pkg::ST_RANGE;
                end else begin
                    o_ctl.del   = i_fire;
                    o_res.count = i_count - 1'b1;
                end
            end
            default: begin
                o_res.status = ils_pkg::ST_RANGE;
            end
        endcase
    end

endmodule

// ===== sv/indexed_list_store.sv =====
// Top level of the indexed list store: command decoder, chain of cells,
// read-select pipeline and output register.
// Depends on ils_pkg, ils_dec and ils_cell.
//
// Input channel i_in_valid / o_in_ready carries one command beat
// (command, position, value); output channel o_out_valid / i_out_ready
// carries one result beat (read_value, status, entry_count) per command.
// The chain of cells shifts in the cycle a beat is accepted, every cell
// comparing its own place with the position, so commands are taken one
// per cycle. A read is gated by each cell, ORed through a registered
// group stage and held in an output register: the result of a beat
// passes the group stage and then the output register, and a throughput of
// one beat per cycle is sustained while the receiver keeps up.
// When the receiver stalls, the group stage and the output register fill
// and o_in_ready falls; nothing is lost or repeated.
// Reset empties the list (count zero) and drops both pipeline stages;
// the stored words themselves are not cleared and are only read after
// they have been written.
module indexed_list_store (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ils_pkg::t_in_beat     i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ils_pkg::t_out_beat    o_out_beat
);

    logic                            w_fire;
    logic                            w_out_adv;
    ils_pkg::t_cell_ctl              w_ctl;
    ils_pkg::t_dec_res               w_res;
    logic [ils_pkg::WORD_WIDTH-1:0]  w_word    [ils_pkg::DEPTH];
    logic [ils_pkg::WORD_WIDTH-1:0]  w_rd_word [ils_pkg::DEPTH];
    logic [ils_pkg::WORD_WIDTH-1:0]  n_grp     [ils_pkg::GRP_NUM];
    logic [ils_pkg::WORD_WIDTH-1:0]  r_grp     [ils_pkg::GRP_NUM];
    logic [ils_pkg::WORD_WIDTH-1:0]  w_sel;
    logic [ils_pkg::CNT_W-1:0]       r_count;
    logic                            r_s1_vld;
    ils_pkg::t_dec_res               r_s1_res;
    logic                            r_out_vld;
    ils_pkg::t_out_beat              r_out_beat;
    ils_pkg::t_out_beat              n_out_beat;

    assign w_out_adv  = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_s1_vld || w_out_adv;
    assign w_fire     = i_in_valid && o_in_ready;

    ils_dec u_dec (
        .i_fire  (w_fire),
        .i_beat  (i_in_beat),
        .i_count (r_count),
        .o_ctl   (w_ctl),
        .o_res   (w_res)
    );

    for (genvar g = 0; g < ils_pkg::DEPTH; g++) begin : g_cell
        logic [ils_pkg::WORD_WIDTH-1:0] w_prev;
        logic [ils_pkg::WORD_WIDTH-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = w_ctl.word;
        end else begin : g_mid
            assign w_prev = w_word[g-1];
        end
        if (g == ils_pkg::DEPTH - 1) begin : g_last
            assign w_next = w_word[g];
        end else begin : g_body
            assign w_next = w_word[g+1];
        end
        ils_cell u_cell (
            .i_clk     (i_clk),
            .i_index   (ils_pkg::CMP_W'(g)),
            .i_ctl     (w_ctl),
            .i_prev    (w_prev),
            .i_next    (w_next),
            .o_word    (w_word[g]),
            .o_rd_word (w_rd_word[g])
        );
    end

    always_comb begin
        for (int gi = 0; gi < ils_pkg::GRP_NUM; gi++) begin
            n_grp[gi] = '0;
            for (int k = 0; k < ils_pkg::GRP_SIZE; k++) begin
                if (gi * ils_pkg::GRP_SIZE + k < ils_pkg::DEPTH) begin
                    n_grp[gi] = n_grp[gi] | w_rd_word[gi * ils_pkg::GRP_SIZE + k];
                end
            end
        end
    end

    always_comb begin
        w_sel = '0;
        for (int gi = 0; gi < ils_pkg::GRP_NUM; gi++) begin
            w_sel = w_sel | r_grp[gi];
        end
    end

    always_comb begin
        n_out_beat.status      = r_s1_res.status;
        n_out_beat.entry_count = 7'(r_s1_res.count);
        if (!r_s1_res.is_read) begin
            n_out_beat.read_value = '0;
        end else if (r_s1_res.status == ils_pkg::ST_DONE) begin
            n_out_beat.read_value = 32'(signed'(w_sel));
        end else begin
            n_out_beat.read_value = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count <= w_res.count;
            end
            if (w_fire) begin
                r_s1_vld <= 1'b1;
            end else if (w_out_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_out_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_s1_res <= w_res;
            r_grp    <= n_grp;
        end
        if (w_out_adv && r_s1_vld) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out_beat;

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1
                    || r_count + 1'b1 == $past(r_count)))
        else $error("entry count moved by more than one on a single beat");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status == ils_pkg::ST_FULL)
        |-> (o_out_beat.entry_count == 7'(ils_pkg::DEPTH)))
        else $error("full status reported with the list not full");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_vld && r_out_vld && !i_out_ready))
        else $error("input stalled without a blocked output");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_count <= ils_pkg::CNT_W'(ils_pkg::DEPTH)))
        else $error("entry count beyond the store depth");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for indexed_list_store: drives command beats, predicts
// each result beat from its own copy of the list and checks them in order.
// Depends on ils_pkg and the indexed_list_store RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_GAP     = 18;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    ils_pkg::t_in_beat  in_beat   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    ils_pkg::t_out_beat out_beat;

    logic [ils_pkg::WORD_WIDTH-1:0] list_words [ils_pkg::DEPTH];
    int                             list_len  = 0;
    ils_pkg::t_out_beat             due_replies [$];
    int                             mismatches = 0;
    int                             cycles     = 0;
    int                             rx_stall   = 0;
    int                             rx_hold    = 0;
    bit                             tx_calm    = 1'b0;
    bit                             rx_calm    = 1'b0;

    indexed_list_store DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    always #6 clk = ~clk;

    function automatic logic [1:0] insert_word(input int at, input logic [31:0] v);
        if (list_len >= ils_pkg::DEPTH) begin
            return ils_pkg::ST_FULL;
        end
        for (int i = list_len; i > at; i--) begin
            list_words[i] = list_words[i - 1];
        end
        list_words[at] = ils_pkg::WORD_WIDTH'(v);
        list_len++;
        return ils_pkg::ST_DONE;
    endfunction

    function automatic ils_pkg::t_out_beat run_list_command(input ils_pkg::t_in_beat b);
        ils_pkg::t_out_beat r;
        int                 p;
        r = '0;
        p = $signed(b.position);
        case (b.command)
            ils_pkg::CMD_READ: begin
                if (p < 0 || p >= list_len) begin
                    r.read_value = '1;
                    r.status     = ils_pkg::ST_RANGE;
                end else begin
                    r.read_value = $signed(list_words[p]);
                end
            end
            ils_pkg::CMD_INS_HEAD: r.status = insert_word(0, b.value);
            ils_pkg::CMD_INS_TAIL: r.status = insert_word(list_len, b.value);
            ils_pkg::CMD_INS_POS: begin
                if (p < 0 || p > list_len) begin
                    r.status = ils_pkg::ST_RANGE;
                end else begin
                    r.status = insert_word(p, b.value);
                end
            end
            ils_pkg::CMD_DEL_POS: begin
                if (p < 0 || p >= list_len) begin
                    r.status = ils_pkg::ST_RANGE;
                end else begin
                    for (int i = p; i < list_len - 1; i++) begin
                        list_words[i] = list_words[i + 1];
                    end
                    list_len--;
                end
            end
            default: r.status = ils_pkg::ST_RANGE;
        endcase
        r.entry_count = 7'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic send_beat(input ils_pkg::t_in_beat b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        due_replies.push_back(run_list_command(b));
    endtask

    task automatic send_op(input logic [2:0] cmd, input int pos, input logic [31:0] val);
        ils_pkg::t_in_beat b;
        b.command  = cmd;
        b.position = 8'(pos);
        b.value    = val;
        send_beat(b);
    endtask

    function automatic ils_pkg::t_in_beat random_command(input bit grow);
        ils_pkg::t_in_beat b;
        int                pick;
        int                span;
        b.command  = ils_pkg::CMD_READ;
        b.position = 8'($urandom);
        b.value    = $urandom;
        pick = $urandom_range(0, 99);
        span = (list_len > 0) ? list_len - 1 : 0;
        if (pick < 8) begin
            b.command = 3'($urandom_range(0, 7));
        end else if (pick < (grow ? 62 : 26)) begin
            case ($urandom_range(0, 2))
                0: b.command = ils_pkg::CMD_INS_HEAD;
                1: b.command = ils_pkg::CMD_INS_TAIL;
                default: begin
                    b.command  = ils_pkg::CMD_INS_POS;
                    b.position = 8'($urandom_range(0, list_len));
                end
            endcase
        end else if (pick < (grow ? 80 : 44)) begin
            b.position = 8'($urandom_range(0, span));
        end else begin
            b.command  = ils_pkg::CMD_DEL_POS;
            b.position = ($urandom_range(0, 19) == 0) ? 8'(list_len) : 8'($urandom_range(0, span));
        end
        return b;
    endfunction

    task automatic test_directed_edges();
        send_op(ils_pkg::CMD_READ, 0, 32'h0);
        send_op(ils_pkg::CMD_DEL_POS, 0, 32'h0);
        send_op(ils_pkg::CMD_INS_POS, 1, 32'h1234_5678);
        send_op(ils_pkg::CMD_INS_POS, -128, 32'h1234_5678);
        send_op(ils_pkg::CMD_INS_HEAD, 127, 32'h7FFF_FFFF);
        send_op(ils_pkg::CMD_INS_TAIL, -128, 32'h8000_0000);
        send_op(ils_pkg::CMD_INS_POS, 1, 32'hFFFF_FFFF);
        send_op(ils_pkg::CMD_INS_POS, 3, 32'h0);
        send_op(ils_pkg::CMD_INS_POS, 0, 32'h5A5A_A5A5);
        for (int i = 0; i < 5; i++) begin
            send_op(ils_pkg::CMD_READ, i, 32'hFFFF_FFFF);
        end
        send_op(ils_pkg::CMD_READ, 5, 32'h0);
        send_op(ils_pkg::CMD_READ, -1, 32'h0);
        send_op(ils_pkg::CMD_READ, 127, 32'h0);
        send_op(ils_pkg::CMD_READ, -128, 32'h0);
        send_op(ils_pkg::CMD_DEL_POS, 127, 32'h0);
        send_op(ils_pkg::CMD_DEL_POS, -128, 32'h0);
        send_op(ils_pkg::CMD_DEL_POS, 5, 32'h0);
        send_op(ils_pkg::CMD_DEL_POS, 2, 32'h0);
        send_op(ils_pkg::CMD_DEL_POS, 0, 32'h0);
        send_op(ils_pkg::CMD_DEL_POS, list_len - 1, 32'h0);
        send_op(3'd5, 0, 32'hDEAD_BEEF);
        send_op(3'd6, 1, 32'h0);
        send_op(3'd7, -1, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_store();
        while (list_len < ils_pkg::DEPTH) begin
            case ($urandom_range(0, 2))
                0: send_op(ils_pkg::CMD_INS_HEAD, $urandom_range(0, 255), $urandom);
                1: send_op(ils_pkg::CMD_INS_TAIL, $urandom_range(0, 255), $urandom);
                default: send_op(ils_pkg::CMD_INS_POS, $urandom_range(0, list_len), $urandom);
            endcase
        end
        send_op(ils_pkg::CMD_INS_HEAD, 0, $urandom);
        send_op(ils_pkg::CMD_INS_TAIL, 0, $urandom);
        send_op(ils_pkg::CMD_INS_POS, ils_pkg::DEPTH, $urandom);
        send_op(ils_pkg::CMD_INS_POS, ils_pkg::DEPTH + 1, $urandom);
        send_op(ils_pkg::CMD_INS_POS, -1, $urandom);
        send_op(ils_pkg::CMD_READ, ils_pkg::DEPTH - 1, 32'h0);
        send_op(ils_pkg::CMD_READ, ils_pkg::DEPTH, 32'h0);
        send_op(ils_pkg::CMD_DEL_POS, ils_pkg::DEPTH, 32'h0);
        send_op(ils_pkg::CMD_DEL_POS, ils_pkg::DEPTH - 1, 32'h0);
        send_op(ils_pkg::CMD_INS_POS, ils_pkg::DEPTH - 1, 32'h8000_0000);
        send_op(ils_pkg::CMD_READ, ils_pkg::DEPTH - 1, 32'h0);
        while (list_len > 0) begin
            send_op(ils_pkg::CMD_READ, $urandom_range(0, list_len - 1), 32'h0);
            send_op(ils_pkg::CMD_DEL_POS, $urandom_range(0, list_len - 1), 32'h0);
        end
        send_op(ils_pkg::CMD_READ, 0, 32'h0);
    endtask

    task automatic test_backpressure();
        tx_calm = 1'b1;
        rx_hold = 300;
        for (int n = 0; n < 80; n++) begin
            send_beat(random_command(list_len < ils_pkg::DEPTH / 2));
        end
        tx_calm = 1'b0;
    endtask

    task automatic test_random_mix();
        bit grow;
        grow = 1'b1;
        for (int n = 0; n < 1250; n++) begin
            if (n % 100 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (list_len >= ils_pkg::DEPTH && $urandom_range(0, 3) == 0) begin
                grow = 1'b0;
            end else if (list_len < 3) begin
                grow = 1'b1;
            end
            send_beat(random_command(grow));
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // The receiver's own stall and long hold-off are both counted here, one per cycle.
    initial begin : result_sink
        forever begin
            @(negedge clk);
            if (rx_calm) begin
                rx_stall = 0;
            end
            if (rx_hold > 0) begin
                out_ready <= 1'b0;
                rx_hold--;
            end else if (rx_stall > 0) begin
                out_ready <= 1'b0;
                rx_stall--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : result_check
        ils_pkg::t_out_beat want;
        if (rst_n && out_valid && out_ready) begin
            rx_stall = $urandom_range(0, MAX_GAP);
            if (due_replies.size() == 0) begin
                report_mismatch("result beat with no command outstanding");
            end else begin
                want = due_replies.pop_front();
                if (out_beat.read_value !== want.read_value) begin
                    report_mismatch($sformatf("read_value %0d, expected %0d",
                                              out_beat.read_value, want.read_value));
                end
                if (out_beat.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              out_beat.status, want.status));
                end
                if (out_beat.entry_count !== want.entry_count) begin
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              out_beat.entry_count, want.entry_count));
                end
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("indexed_list_store verification failed");
        $finish;
    end

    initial begin : test_sequence
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_edges();
        test_full_store();
        test_backpressure();
        test_random_mix();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0) begin
            $display("indexed_list_store verification clean");
        end else begin
            $display("indexed_list_store verification failed");
        end
        $finish;
    end

endmodule
